// ===== rtl/ll2s_pkg.sv =====
`timescale 1ns / 1ps
// ll2s_pkg: shared widths, constants, side-band type and helper functions
// for the lat/lon to unit-sphere pipeline. No dependencies.
package ll2s_pkg;

   localparam int CORDIC_STAGES_DEFAULT = 18;

   // field widths
   localparam int LAT_W   = 24;
   localparam int LON_W   = 25;
   localparam int SPH_W   = 18;
   localparam int FLATX_W = 18;
   localparam int FLATY_W = 17;

   // internal widths
   localparam int MAG_W   = 23;  // |angle| in degrees Q16 after saturation/fold
   localparam int ANGLE_W = 32;  // radians, Q30, signed
   localparam int CORD_W  = 34;  // CORDIC x/y/z datapath
   localparam int MULT_W  = 33;  // operand width of the output products

   localparam int ANGLE_LATENCY   = 5;
   localparam int COMBINE_LATENCY = 2;

   localparam logic signed [LAT_W-1:0] LAT_LIMIT  = 24'sd5898240;
   localparam logic signed [LON_W-1:0] LON_LIMIT  = 25'sd11796480;
   localparam logic signed [LON_W-1:0] FOLD_LIMIT = 25'sd5898240;

   // pi in Q32 is 0x3_243F6A88: low 32 bits here, top bits are 3
   localparam logic [31:0] PI_Q32_LO = 32'h243F6A88;
   // 180 * 2^17: rounding offset for the degree to radian divide
   localparam logic [24:0] DEG_ROUND = 25'd23592960;

   localparam logic signed [CORD_W-1:0] INV_GAIN_Q30 = 34'sh26DD3B6A;

   // floor(v / 45) for v < 2^25: (v * ceil(2^31 / 45)) >> 31
   localparam logic [25:0] DIV45_MUL = 26'd47721859;

   // flat outputs: 45 * 2^16 added so the divide stays unsigned
   localparam logic signed [25:0] FLAT_BIAS   = 26'sd2949120;
   localparam logic signed [20:0] FLAT_UNBIAS = 21'sd65536;

   typedef struct packed {
      logic                     last;
      logic                     negc;   // longitude folded, cosine negated
      logic signed [LAT_W-1:0]  lat;    // saturated latitude
      logic signed [LON_W-1:0]  lon;    // saturated longitude
   } side_type;

   function automatic logic [19:0] div45(input logic [24:0] v);
      logic [50:0] p;
      p = 51'(v) * 51'(DIV45_MUL);
      return p[50:31];
   endfunction

   // atan(2^-i), Q30, rounded
   function automatic logic [31:0] atan_q30(input int i);
      logic [31:0] a;
      case (i)
         0:       a = 32'd843314857;
         1:       a = 32'd497837829;
         2:       a = 32'd263043837;
         3:       a = 32'd133525159;
         4:       a = 32'd67021687;
         5:       a = 32'd33543516;
         6:       a = 32'd16775851;
         7:       a = 32'd8388437;
         8:       a = 32'd4194283;
         9:       a = 32'd2097149;
         10:      a = 32'd1048576;
         31:      a = 32'd1;
         default: a = 32'd1 << (30 - i);
      endcase
      return a;
   endfunction

endpackage

// ===== rtl/ll2s_angle.sv =====
`timescale 1ns / 1ps
// ll2s_angle: degrees (Q16 magnitude + sign) to radians (Q30), five stages.
// Divide by 180*2^18 done as a shift and two digit steps of a divide by 45. Uses ll2s_pkg.
module ll2s_angle (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   input  logic [ll2s_pkg::MAG_W-1:0]          in_mag,
   input  logic                                in_neg,
   output logic                                out_valid,
   output logic signed [ll2s_pkg::ANGLE_W-1:0] out_angle
);

   localparam int MW = ll2s_pkg::MAG_W;

   logic [4:0] valid_ff;
   logic [3:0] neg_ff;

   // stage 1: low partial product
   logic [MW+31:0] prod_ff;
   logic [MW-1:0]  mag_ff;

   // stage 2: numerator >> 20, split in two digits
   logic [56:0] sum_in;
   logic [17:0] hi2_ff;
   logic [18:0] lo2_ff;

   // stage 3: high quotient digit
   logic [19:0] q1_full;
   logic [12:0] q1_3_ff;
   logic [17:0] hi3_ff;
   logic [18:0] lo3_ff;

   // stage 4: remainder joined with low digit
   logic [17:0] rem_in;
   logic [24:0] v4_ff;
   logic [12:0] q1_4_ff;

   // stage 5: low quotient digit, sign
   logic [19:0] q0_full;
   logic [31:0] rad_mag;
   logic signed [ll2s_pkg::ANGLE_W-1:0] angle_in;
   logic signed [ll2s_pkg::ANGLE_W-1:0] angle_ff;

   always_comb begin
      sum_in   = 57'(prod_ff) + ((57'(mag_ff) * 57'd3) << 32) + 57'(ll2s_pkg::DEG_ROUND);
      q1_full  = ll2s_pkg::div45({7'd0, hi2_ff});
      rem_in   = hi3_ff - (18'(q1_3_ff) * 18'd45);
      q0_full  = ll2s_pkg::div45(v4_ff);
      rad_mag  = {q1_4_ff, q0_full[18:0]};
      angle_in = neg_ff[3] ? -$signed(rad_mag) : $signed(rad_mag);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[3:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      neg_ff   <= {neg_ff[2:0], in_neg};
      prod_ff  <= (MW+32)'(in_mag) * (MW+32)'(ll2s_pkg::PI_Q32_LO);
      mag_ff   <= in_mag;
      hi2_ff   <= sum_in[56:39];
      lo2_ff   <= sum_in[38:20];
      q1_3_ff  <= q1_full[12:0];
      hi3_ff   <= hi2_ff;
      lo3_ff   <= lo2_ff;
      v4_ff    <= {rem_in[5:0], lo3_ff};
      q1_4_ff  <= q1_3_ff;
      angle_ff <= angle_in;
   end

   assign out_valid = valid_ff[4];
   assign out_angle = angle_ff;

endmodule

// ===== rtl/ll2s_cordic.sv =====
`timescale 1ns / 1ps
// ll2s_cordic: rotation-mode CORDIC, one register stage per iteration.
// Gives cos and sin in Q30. Uses ll2s_pkg (atan table, inverse gain).
module ll2s_cordic #(
   parameter int STAGES = ll2s_pkg::CORDIC_STAGES_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   input  logic signed [ll2s_pkg::ANGLE_W-1:0] in_angle,
   output logic                                out_valid,
   output logic signed [ll2s_pkg::CORD_W-1:0]  out_cos,
   output logic signed [ll2s_pkg::CORD_W-1:0]  out_sin
);

   localparam int CW = ll2s_pkg::CORD_W;

   logic signed [CW-1:0] x_ff [STAGES];
   logic signed [CW-1:0] y_ff [STAGES];
   logic signed [CW-1:0] z_ff [STAGES];
   logic [STAGES-1:0]    valid_ff;

   for (genvar i = 0; i < STAGES; i++) begin : g_stage
      localparam logic signed [CW-1:0] ATAN = {{(CW-32){1'b0}}, ll2s_pkg::atan_q30(i)};
      logic signed [CW-1:0] x_prev, y_prev, z_prev;
      logic signed [CW-1:0] x_in, y_in, z_in;
      logic                 valid_prev;

      if (i == 0) begin : g_head
         assign x_prev     = ll2s_pkg::INV_GAIN_Q30;
         assign y_prev     = '0;
         assign z_prev     = CW'(in_angle);
         assign valid_prev = in_valid;
      end else begin : g_body
         assign x_prev     = x_ff[i-1];
         assign y_prev     = y_ff[i-1];
         assign z_prev     = z_ff[i-1];
         assign valid_prev = valid_ff[i-1];
      end

      always_comb begin
         if (!z_prev[CW-1]) begin
            x_in = x_prev - (y_prev >>> i);
            y_in = y_prev + (x_prev >>> i);
            z_in = z_prev - ATAN;
         end else begin
            x_in = x_prev + (y_prev >>> i);
            y_in = y_prev - (x_prev >>> i);
            z_in = z_prev + ATAN;
         end
      end

      always_ff @(posedge clock) begin
         x_ff[i] <= x_in;
         y_ff[i] <= y_in;
         z_ff[i] <= z_in;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else begin
            valid_ff[i] <= valid_prev;
         end
      end
   end

   assign out_valid = valid_ff[STAGES-1];
   assign out_cos   = x_ff[STAGES-1];
   assign out_sin   = y_ff[STAGES-1];

endmodule

// ===== rtl/ll2s_combine.sv =====
`timescale 1ns / 1ps
// ll2s_combine: output products, rounding, clamping and the flat divide by 180.
// Two stages, the second is the result register. Uses ll2s_pkg.
module ll2s_combine (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   input  logic signed [ll2s_pkg::CORD_W-1:0]  in_cos_lat,
   input  logic signed [ll2s_pkg::CORD_W-1:0]  in_sin_lat,
   input  logic signed [ll2s_pkg::CORD_W-1:0]  in_cos_lon,
   input  logic signed [ll2s_pkg::CORD_W-1:0]  in_sin_lon,
   input  ll2s_pkg::side_type                  in_side,
   output logic                                out_valid,
   output logic signed [ll2s_pkg::SPH_W-1:0]   out_sphere_x,
   output logic signed [ll2s_pkg::SPH_W-1:0]   out_sphere_y,
   output logic signed [ll2s_pkg::SPH_W-1:0]   out_sphere_z,
   output logic signed [ll2s_pkg::FLATX_W-1:0] out_flat_x,
   output logic signed [ll2s_pkg::FLATY_W-1:0] out_flat_y,
   output logic                                out_last
);

   localparam int CW = ll2s_pkg::CORD_W;
   localparam int MW = ll2s_pkg::MULT_W;
   localparam int PW = 2 * MW;

   function automatic logic signed [ll2s_pkg::SPH_W-1:0] clamp_unit(
      input logic signed [21:0] v
   );
      logic signed [ll2s_pkg::SPH_W-1:0] r;
      if (v > 22'sd65536) begin
         r = 18'sd65536;
      end else if (v < -22'sd65536) begin
         r = -18'sd65536;
      end else begin
         r = v[ll2s_pkg::SPH_W-1:0];
      end
      return r;
   endfunction

   // stage A
   logic signed [CW-1:0] cos_lon_adj;
   logic signed [MW-1:0] op_cl, op_sl, op_co;
   logic signed [CW-1:0] sy_sum;
   logic signed [25:0]   nx, ny, mx, my;
   logic signed [PW-1:0] px_ff, pz_ff;
   logic signed [19:0]   sy_ff;
   logic [22:0]          mx_ff, my_ff;
   logic                 last_a_ff;
   logic                 valid_a_ff;

   // stage B
   logic signed [PW-1:0] rx, rz;
   logic signed [20:0]   fx, fy;

   always_comb begin
      cos_lon_adj = in_side.negc ? -in_cos_lon : in_cos_lon;
      op_cl  = in_cos_lat[MW-1:0];
      op_sl  = in_sin_lon[MW-1:0];
      op_co  = cos_lon_adj[MW-1:0];
      sy_sum = in_sin_lat + 34'sd8192;
      // floor((v + 90) / 180) = floor(floor((v + 90) / 4) / 45)
      nx = 26'(in_side.lon) + 26'sd90;
      ny = 26'(in_side.lat) + 26'sd90;
      mx = (nx >>> 2) + ll2s_pkg::FLAT_BIAS;
      my = (ny >>> 2) + ll2s_pkg::FLAT_BIAS;
   end

   always_comb begin
      rx = px_ff + (66'sd1 <<< 43);
      rz = pz_ff + (66'sd1 <<< 43);
      fx = $signed({1'b0, ll2s_pkg::div45({2'b00, mx_ff})}) - ll2s_pkg::FLAT_UNBIAS;
      fy = $signed({1'b0, ll2s_pkg::div45({2'b00, my_ff})}) - ll2s_pkg::FLAT_UNBIAS;
   end

   always_ff @(posedge clock) begin
      px_ff     <= PW'(op_cl) * PW'(op_sl);
      pz_ff     <= PW'(op_cl) * PW'(op_co);
      sy_ff     <= sy_sum[CW-1:14];
      mx_ff     <= mx[22:0];
      my_ff     <= my[22:0];
      last_a_ff <= in_side.last;

      out_sphere_x <= clamp_unit(rx[PW-1:44]);
      out_sphere_y <= clamp_unit(22'(sy_ff));
      out_sphere_z <= clamp_unit(rz[PW-1:44]);
      out_flat_x   <= fx[ll2s_pkg::FLATX_W-1:0];
      out_flat_y   <= fy[ll2s_pkg::FLATY_W-1:0];
      out_last     <= last_a_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
         out_valid  <= 1'b0;
      end else begin
         valid_a_ff <= in_valid;
         out_valid  <= valid_a_ff;
      end
   end

endmodule

// ===== rtl/latlon_to_unit_sphere.sv =====
`timescale 1ns / 1ps
// latlon_to_unit_sphere: top level of the grid point to unit-sphere pipeline.
// Depends on ll2s_pkg, ll2s_angle, ll2s_cordic and ll2s_combine.

// One grid point is taken on every clock edge at which start is high; busy is
// tied low, so points may be issued back to back with no gaps. Each point gives
// exactly one result, shown for a single cycle with rsp_valid, once it has passed
// through 1 input stage, 5 stages of degree to radian conversion, one stage per
// CORDIC iteration and 2 output stages. The receiver has no way to hold a
// result off and must take it in that cycle. Latitude saturates to +-90
// degrees and longitude to +-180 degrees before any use; longitudes beyond
// +-90 degrees are folded and the cosine negated. Sphere outputs are clamped
// to +-1.0 (Q16).
module latlon_to_unit_sphere #(
   parameter int CORDIC_STAGES = ll2s_pkg::CORDIC_STAGES_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic signed [ll2s_pkg::LAT_W-1:0]   req_latitude,
   input  logic signed [ll2s_pkg::LON_W-1:0]   req_longitude,
   input  logic                                req_last_point,
   output logic                                rsp_valid,
   output logic signed [ll2s_pkg::SPH_W-1:0]   rsp_sphere_x,
   output logic signed [ll2s_pkg::SPH_W-1:0]   rsp_sphere_y,
   output logic signed [ll2s_pkg::SPH_W-1:0]   rsp_sphere_z,
   output logic signed [ll2s_pkg::FLATX_W-1:0] rsp_flat_x,
   output logic signed [ll2s_pkg::FLATY_W-1:0] rsp_flat_y,
   output logic                                rsp_last_out
);

   localparam int MW         = ll2s_pkg::MAG_W;
   localparam int SIDE_DEPTH = ll2s_pkg::ANGLE_LATENCY + CORDIC_STAGES;
   localparam int LATENCY    = 1 + SIDE_DEPTH + ll2s_pkg::COMBINE_LATENCY;

   // pipeline never stalls
   assign busy = 1'b0;

   // ---------------------------------------------------------------------
   // Input stage: saturate, fold longitude into +-90, split sign/magnitude
   // ---------------------------------------------------------------------
   logic signed [ll2s_pkg::LAT_W-1:0] lat_sat;
   logic signed [ll2s_pkg::LON_W-1:0] lon_sat;
   logic signed [ll2s_pkg::LAT_W-1:0] lat_abs;
   logic signed [ll2s_pkg::LON_W-1:0] flon_abs;
   logic                              flon_neg;
   logic                              fold;

   always_comb begin
      if (req_latitude > ll2s_pkg::LAT_LIMIT) begin
         lat_sat = ll2s_pkg::LAT_LIMIT;
      end else if (req_latitude < -ll2s_pkg::LAT_LIMIT) begin
         lat_sat = -ll2s_pkg::LAT_LIMIT;
      end else begin
         lat_sat = req_latitude;
      end

      if (req_longitude > ll2s_pkg::LON_LIMIT) begin
         lon_sat = ll2s_pkg::LON_LIMIT;
      end else if (req_longitude < -ll2s_pkg::LON_LIMIT) begin
         lon_sat = -ll2s_pkg::LON_LIMIT;
      end else begin
         lon_sat = req_longitude;
      end

      lat_abs = lat_sat[ll2s_pkg::LAT_W-1] ? -lat_sat : lat_sat;

      // beyond +-90: 180 - lon or -180 - lon, same sine, negated cosine
      priority if (lon_sat > ll2s_pkg::FOLD_LIMIT) begin
         flon_abs = ll2s_pkg::LON_LIMIT - lon_sat;
         flon_neg = 1'b0;
         fold     = 1'b1;
      end else if (lon_sat < -ll2s_pkg::FOLD_LIMIT) begin
         flon_abs = ll2s_pkg::LON_LIMIT + lon_sat;
         flon_neg = 1'b1;
         fold     = 1'b1;
      end else if (lon_sat[ll2s_pkg::LON_W-1]) begin
         flon_abs = -lon_sat;
         flon_neg = 1'b1;
         fold     = 1'b0;
      end else begin
         flon_abs = lon_sat;
         flon_neg = 1'b0;
         fold     = 1'b0;
      end
   end

   logic               in_valid_ff;
   logic [MW-1:0]      lat_mag_ff;
   logic               lat_neg_ff;
   logic [MW-1:0]      lon_mag_ff;
   logic               lon_neg_ff;
   ll2s_pkg::side_type side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= start & ~busy;
      end
   end

   always_ff @(posedge clock) begin
      lat_mag_ff   <= lat_abs[MW-1:0];
      lat_neg_ff   <= lat_sat[ll2s_pkg::LAT_W-1];
      lon_mag_ff   <= flon_abs[MW-1:0];
      lon_neg_ff   <= flon_neg;
      side_ff.last <= req_last_point;
      side_ff.negc <= fold;
      side_ff.lat  <= lat_sat;
      side_ff.lon  <= lon_sat;
   end

   // ---------------------------------------------------------------------
   // Side-band line: carries flag, fold and saturated angles alongside the
   // angle conversion and CORDIC stages
   // ---------------------------------------------------------------------
   ll2s_pkg::side_type side_line_ff [SIDE_DEPTH];

   always_ff @(posedge clock) begin
      side_line_ff[0] <= side_ff;
      for (int k = 1; k < SIDE_DEPTH; k++) begin
         side_line_ff[k] <= side_line_ff[k-1];
      end
   end

   // ---------------------------------------------------------------------
   // Degrees to radians, one converter per angle
   // ---------------------------------------------------------------------
   logic                                lat_ang_valid, lon_ang_valid;
   logic signed [ll2s_pkg::ANGLE_W-1:0] lat_angle, lon_angle;

   ll2s_angle u_lat_angle (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (in_valid_ff),
      .in_mag    (lat_mag_ff),
      .in_neg    (lat_neg_ff),
      .out_valid (lat_ang_valid),
      .out_angle (lat_angle)
   );

   ll2s_angle u_lon_angle (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (in_valid_ff),
      .in_mag    (lon_mag_ff),
      .in_neg    (lon_neg_ff),
      .out_valid (lon_ang_valid),
      .out_angle (lon_angle)
   );

   // ---------------------------------------------------------------------
   // CORDIC rotators
   // ---------------------------------------------------------------------
   logic                               lat_trig_valid, lon_trig_valid;
   logic signed [ll2s_pkg::CORD_W-1:0] cos_lat, sin_lat, cos_lon, sin_lon;

   ll2s_cordic #(.STAGES(CORDIC_STAGES)) u_lat_cordic (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (lat_ang_valid),
      .in_angle  (lat_angle),
      .out_valid (lat_trig_valid),
      .out_cos   (cos_lat),
      .out_sin   (sin_lat)
   );

   ll2s_cordic #(.STAGES(CORDIC_STAGES)) u_lon_cordic (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (lon_ang_valid),
      .in_angle  (lon_angle),
      .out_valid (lon_trig_valid),
      .out_cos   (cos_lon),
      .out_sin   (sin_lon)
   );

   // ---------------------------------------------------------------------
   // Products, rounding, flat coordinates, result register
   // ---------------------------------------------------------------------
   ll2s_combine u_combine (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (lat_trig_valid),
      .in_cos_lat   (cos_lat),
      .in_sin_lat   (sin_lat),
      .in_cos_lon   (cos_lon),
      .in_sin_lon   (sin_lon),
      .in_side      (side_line_ff[SIDE_DEPTH-1]),
      .out_valid    (rsp_valid),
      .out_sphere_x (rsp_sphere_x),
      .out_sphere_y (rsp_sphere_y),
      .out_sphere_z (rsp_sphere_z),
      .out_flat_x   (rsp_flat_x),
      .out_flat_y   (rsp_flat_y),
      .out_last     (rsp_last_out)
   );

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   // a result only ever follows a matching transfer at the pipeline input
   a_result_has_transfer: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, LATENCY))
      else $error("result without matching transfer");

   // the two angle paths stay in lock step
   a_paths_aligned: assert property (@(posedge clock) disable iff (reset)
      lat_trig_valid == lon_trig_valid)
      else $error("latitude and longitude paths out of step");

   // last flag lines up with its own point
   a_last_aligned: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_last_out == $past(req_last_point, LATENCY))
      else $error("last flag misaligned");

   // flat latitude stays within +-0.5
   a_flat_y_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_flat_y >= -17'sd32768) && (rsp_flat_y <= 17'sd32768))
      else $error("flat_y out of range");

endmodule
